@@ src/clpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Content-Length deframer package
// Shared constants, state encodings, result type and the header prefix table.
// ----------------------------------------------------------------------------
package clpd_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int PREFIX_LEN  = 16;
    localparam int POS_BITS    = $clog2(PREFIX_LEN + 1);
    localparam int IDX_BITS    = $clog2(PREFIX_LEN);
    localparam int LIMIT_BITS  = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 4;

    localparam logic [LIMIT_BITS-1:0] LENGTH_CAP =
        LIMIT_BITS'((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [31:0] MAX_LENGTH_RESET = 32'd1048576;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [2:0] {
        MODE_HUNT,
        MODE_AFTER_CR,
        MODE_SEP,
        MODE_PAYLOAD,
        MODE_HALT
    } mode_t;

    typedef enum logic [1:0] {
        PH_BEFORE,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_ERROR   = 2'd2
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] data_byte;
        logic       last;
    } result_t;

    function automatic logic [7:0] prefix_char(input logic [IDX_BITS-1:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h4C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            4'd14:   ch = 8'h3A;
            4'd15:   ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ src/clpd_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module clpd_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       consume,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || consume;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

@@ src/clpd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header parser and payload sequencer
// Checks each header line, accumulates the decimal length and counts out the
// payload bytes of the message.
// ----------------------------------------------------------------------------
module clpd_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_data,
    input  logic                 fire,
    input  logic [7:0]           rx_byte,
    output logic                 emit,
    output clpd_pkg::result_t    result
);

    clpd_pkg::mode_t                         mode_reg, mode_next;
    logic [clpd_pkg::POS_BITS-1:0]           pos_reg, pos_next, pos_f;
    logic                                    match_reg, match_next, match_f;
    clpd_pkg::phase_t                        phase_reg, phase_next, phase_f;
    logic [clpd_pkg::LENGTH_BITS-1:0]        value_reg, value_next, value_f;
    logic                                    bad_reg, bad_next, bad_f;
    logic [clpd_pkg::LENGTH_BITS-1:0]        remain_reg, remain_next;
    logic                                    sep_reg, sep_next;
    logic [31:0]                             max_length_reg;

    logic                                    digit;
    logic                                    blank;
    logic                                    take;
    logic                                    over;
    logic                                    header_ok;
    logic [clpd_pkg::LIMIT_BITS-1:0]         lim_max;
    logic [clpd_pkg::LIMIT_BITS-1:0]         lim;
    logic [clpd_pkg::LIMIT_BITS-1:0]         value_ext;
    logic [clpd_pkg::LIMIT_BITS-1:0]         scaled;

    always_comb
    begin
        digit     = rx_byte inside {[clpd_pkg::CHAR_ZERO:clpd_pkg::CHAR_NINE]};
        blank     = rx_byte inside {clpd_pkg::CHAR_SPACE,
                                    [clpd_pkg::CHAR_TAB:clpd_pkg::CHAR_CR]};
        lim_max   = clpd_pkg::LIMIT_BITS'(max_length_reg);
        lim       = (lim_max > clpd_pkg::LENGTH_CAP) ? clpd_pkg::LENGTH_CAP : lim_max;
        value_ext = clpd_pkg::LIMIT_BITS'(value_reg);
        scaled    = (value_ext << 3) + (value_ext << 1)
                  + clpd_pkg::LIMIT_BITS'(rx_byte[3:0]);
        over      = scaled > lim;

        pos_f   = pos_reg;
        match_f = match_reg;
        phase_f = phase_reg;
        value_f = value_reg;
        bad_f   = bad_reg;
        take    = 1'b0;

        if (pos_reg < clpd_pkg::POS_BITS'(clpd_pkg::PREFIX_LEN))
        begin
            if (rx_byte != clpd_pkg::prefix_char(pos_reg[clpd_pkg::IDX_BITS-1:0]))
            begin
                match_f = 1'b0;
            end
            pos_f = pos_reg + clpd_pkg::POS_BITS'(1);
        end
        else
        begin
            case (phase_reg)
                clpd_pkg::PH_BEFORE:
                begin
                    if (digit)
                    begin
                        phase_f = clpd_pkg::PH_DIGITS;
                        take    = 1'b1;
                    end
                    else if (rx_byte == clpd_pkg::CHAR_PLUS)
                    begin
                        phase_f = clpd_pkg::PH_SIGN;
                    end
                    else if (!blank)
                    begin
                        bad_f   = 1'b1;
                        phase_f = clpd_pkg::PH_DONE;
                    end
                end
                clpd_pkg::PH_SIGN:
                begin
                    if (digit)
                    begin
                        phase_f = clpd_pkg::PH_DIGITS;
                        take    = 1'b1;
                    end
                    else
                    begin
                        bad_f   = 1'b1;
                        phase_f = clpd_pkg::PH_DONE;
                    end
                end
                clpd_pkg::PH_DIGITS:
                begin
                    if (digit)
                    begin
                        take = 1'b1;
                    end
                    else
                    begin
                        phase_f = clpd_pkg::PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (take)
        begin
            if (over)
            begin
                bad_f = 1'b1;
            end
            else
            begin
                value_f = scaled[clpd_pkg::LENGTH_BITS-1:0];
            end
        end
    end

    assign header_ok = match_reg && !bad_reg &&
                       (phase_reg == clpd_pkg::PH_DIGITS || phase_reg == clpd_pkg::PH_DONE);

    always_comb
    begin
        mode_next        = mode_reg;
        pos_next         = pos_reg;
        match_next       = match_reg;
        phase_next       = phase_reg;
        value_next       = value_reg;
        bad_next         = bad_reg;
        remain_next      = remain_reg;
        sep_next         = sep_reg;
        emit             = 1'b0;
        result.status    = clpd_pkg::ST_PAYLOAD;
        result.data_byte = 8'd0;
        result.last      = 1'b0;

        if (fire)
        begin
            case (mode_reg)
                clpd_pkg::MODE_HUNT:
                begin
                    pos_next   = pos_f;
                    match_next = match_f;
                    phase_next = phase_f;
                    value_next = value_f;
                    bad_next   = bad_f;
                    if (rx_byte == clpd_pkg::CHAR_CR)
                    begin
                        mode_next = clpd_pkg::MODE_AFTER_CR;
                    end
                end
                clpd_pkg::MODE_AFTER_CR:
                begin
                    if (rx_byte != clpd_pkg::CHAR_LF)
                    begin
                        pos_next   = pos_f;
                        match_next = match_f;
                        phase_next = phase_f;
                        value_next = value_f;
                        bad_next   = bad_f;
                        mode_next  = clpd_pkg::MODE_HUNT;
                    end
                    else if (!header_ok)
                    begin
                        mode_next     = clpd_pkg::MODE_HALT;
                        emit          = 1'b1;
                        result.status = clpd_pkg::ST_ERROR;
                    end
                    else
                    begin
                        remain_next = value_reg;
                        sep_next    = 1'b0;
                        pos_next    = '0;
                        match_next  = 1'b1;
                        phase_next  = clpd_pkg::PH_BEFORE;
                        value_next  = '0;
                        bad_next    = 1'b0;
                        mode_next   = clpd_pkg::MODE_SEP;
                    end
                end
                clpd_pkg::MODE_SEP:
                begin
                    if (!sep_reg)
                    begin
                        sep_next = 1'b1;
                    end
                    else
                    begin
                        sep_next = 1'b0;
                        if (remain_reg == '0)
                        begin
                            mode_next     = clpd_pkg::MODE_HUNT;
                            emit          = 1'b1;
                            result.status = clpd_pkg::ST_EMPTY;
                            result.last   = 1'b1;
                        end
                        else
                        begin
                            mode_next = clpd_pkg::MODE_PAYLOAD;
                        end
                    end
                end
                clpd_pkg::MODE_PAYLOAD:
                begin
                    remain_next      = remain_reg - clpd_pkg::LENGTH_BITS'(1);
                    emit             = 1'b1;
                    result.data_byte = rx_byte;
                    if (remain_reg == clpd_pkg::LENGTH_BITS'(1))
                    begin
                        result.last = 1'b1;
                        mode_next   = clpd_pkg::MODE_HUNT;
                    end
                end
                clpd_pkg::MODE_HALT:
                begin
                end
                default:
                begin
                    mode_next = clpd_pkg::MODE_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= clpd_pkg::MODE_HUNT;
            pos_reg        <= '0;
            match_reg      <= 1'b1;
            phase_reg      <= clpd_pkg::PH_BEFORE;
            value_reg      <= '0;
            bad_reg        <= 1'b0;
            remain_reg     <= '0;
            sep_reg        <= 1'b0;
            max_length_reg <= clpd_pkg::MAX_LENGTH_RESET;
        end
        else
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            match_reg  <= match_next;
            phase_reg  <= phase_next;
            value_reg  <= value_next;
            bad_reg    <= bad_next;
            remain_reg <= remain_next;
            sep_reg    <= sep_next;
            if (cfg_we)
            begin
                max_length_reg <= cfg_data;
            end
        end
    end

    // Once halted, the parser never leaves the halt state until reset.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == clpd_pkg::MODE_HALT |=> mode_reg == clpd_pkg::MODE_HALT)
        else $error("parser left the halt state");

    // An error result can only be produced on the LF that closes a header line.
    a_error_at_lf: assert property (@(posedge clk) disable iff (!rst_n)
        emit && result.status == clpd_pkg::ST_ERROR |->
            mode_reg == clpd_pkg::MODE_AFTER_CR && rx_byte == clpd_pkg::CHAR_LF)
        else $error("error result outside a line end");

    // The payload phase is only entered with bytes still to deliver.
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == clpd_pkg::MODE_PAYLOAD |-> remain_reg != '0)
        else $error("payload phase with nothing remaining");

    // Every byte consumed in the payload phase produces a result.
    a_payload_emits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && mode_reg == clpd_pkg::MODE_PAYLOAD |-> emit)
        else $error("payload byte dropped");

endmodule

@@ src/clpd_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module clpd_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              emit,
    input  clpd_pkg::result_t result,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output clpd_pkg::result_t held
);

    logic              valid_reg;
    logic              valid_next;
    clpd_pkg::result_t result_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = emit;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && emit)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = result_reg;

endmodule

@@ src/content_length_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Content-Length deframer
// Strips Content-Length header framing from a byte stream and delivers the
// payload bytes of each message, an empty-message mark, or a header error.
// ----------------------------------------------------------------------------
// Channel   Signals                                   Transfer
// input     in_valid, in_ready, rx_byte               in_valid && in_ready
// output    out_valid, out_ready, status,             out_valid && out_ready
//           data_byte, last_of_message
// config    cfg_valid, cfg_ready, cfg_data            cfg_valid && cfg_ready
//
// One byte per cycle is sustained while the output is not stalled: a byte is
// held and parsed in the input register, and its result, if any, appears in
// the result register in the cycle after it is parsed.
// A stalled output holds the result register, and the input register then
// holds its byte; a new byte is taken whenever the held one can advance.
// Reset clears the parser to header hunting and sets max_length to 1048576.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
module content_length_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  data_byte,
    output logic        last_of_message,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              free;
    logic              fire;
    logic              emit;
    clpd_pkg::result_t result;
    clpd_pkg::result_t held;

    assign fire      = byte_valid && free;
    assign cfg_ready = 1'b1;

    clpd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .consume    (fire),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    clpd_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .fire     (fire),
        .rx_byte  (byte_data),
        .emit     (emit),
        .result   (result)
    );

    clpd_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .emit      (emit),
        .result    (result),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .held      (held)
    );

    assign status          = held.status;
    assign data_byte       = held.data_byte;
    assign last_of_message = held.last;

endmodule
